/* hdl/sliding_window_rate_limiter_assert.svh */
// Assertion macros for the sliding window rate limiter
`ifndef SLIDING_WINDOW_RATE_LIMITER_ASSERT_SVH
`define SLIDING_WINDOW_RATE_LIMITER_ASSERT_SVH

// same-cycle implication
`define SWRL_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("swrl assertion failed");

// next-cycle implication
`define SWRL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("swrl assertion failed");

`endif

/* hdl/swrl_pkg.sv */
// Shared types and constants for the sliding window rate limiter
package swrl_pkg;

	localparam int unsigned ORDER_LOG_DEPTH  = 256;
	localparam int unsigned VOLUME_LOG_DEPTH = 256;

	localparam int unsigned TIME_W     = 48;
	localparam int unsigned VOL_W      = 32;
	localparam int unsigned PERIOD_W   = 32;
	localparam int unsigned MAXORD_W   = 9;
	localparam int unsigned MAXVOL_W   = 40;
	localparam int unsigned RUNVOL_W   = 40;
	localparam int unsigned STATUS_W   = 2;
	localparam int unsigned OUT_CNT_W  = 9;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 40;
	localparam int unsigned VLOG_W     = TIME_W + VOL_W;

	localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ORDERS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_VOLUME = 2'd2;

	localparam logic KIND_CHECK = 1'b0;
	localparam logic KIND_SENT  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_LIMIT = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic pop;
		logic push;
	} log_cmd_t;

endpackage

/* hdl/swrl_intf.sv */
// Channel interfaces: request, response and configuration write
interface swrl_req_if;
	logic                          valid;
	logic                          ready;
	logic                          kind;
	logic [swrl_pkg::TIME_W-1:0]   now_ms;
	logic [swrl_pkg::VOL_W-1:0]    order_volume;

	modport source (output valid, kind, now_ms, order_volume, input ready);
	modport sink   (input valid, kind, now_ms, order_volume, output ready);
endinterface

interface swrl_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [swrl_pkg::STATUS_W-1:0]   status;
	logic [swrl_pkg::OUT_CNT_W-1:0]  orders_in_window;
	logic [swrl_pkg::RUNVOL_W-1:0]   volume_in_window;

	modport source (output valid, status, orders_in_window, volume_in_window, input ready);
	modport sink   (input valid, status, orders_in_window, volume_in_window, output ready);
endinterface

interface swrl_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [swrl_pkg::CFG_IDX_W-1:0]   index;
	logic [swrl_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/swrl_ram.sv */
// Generic single-write, single-read RAM with registered read
module swrl_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hdl/swrl_log.sv */
// Circular time log: head/count pointers over a RAM, head entry read ahead
module swrl_log #(
	parameter int unsigned WIDTH = 48,
	parameter int unsigned DEPTH = 256
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  swrl_pkg::log_cmd_t         cmd,
	input  logic [WIDTH-1:0]           wr_data,
	output logic [WIDTH-1:0]           head_data,
	output logic [$clog2(DEPTH+1)-1:0] count,
	output logic                       full
);

	localparam int unsigned IW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [IW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [IW-1:0] head_inc;
	logic [IW-1:0] rd_addr;
	logic [CW:0]   tail_sum;
	logic [CW:0]   tail_wrap;
	logic [IW-1:0] tail;

	always_comb begin
		head_inc  = (head_q == IW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
		rd_addr   = cmd.pop ? head_inc : head_q;
		tail_sum  = (CW+1)'(head_q) + (CW+1)'(count_q);
		tail_wrap = (tail_sum >= (CW+1)'(DEPTH)) ? tail_sum - (CW+1)'(DEPTH) : tail_sum;
		tail      = tail_wrap[IW-1:0];
		full      = (count_q == CW'(DEPTH));
		count     = count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (cmd.pop) begin
			head_q  <= head_inc;
			count_q <= count_q - 1'b1;
		end else if (cmd.push) begin
			count_q <= count_q + 1'b1;
		end
	end

	swrl_ram #(
		.WIDTH (WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.push),
		.waddr (tail),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (head_data)
	);

endmodule

/* hdl/sliding_window_rate_limiter.sv */
// Sliding window rate limiter top level: sequencer, shared compare/add unit, two logs
//
//  channel | dir | payload                                             | handshake
//  --------+-----+-----------------------------------------------------+------------
//  cfg     | in  | index, data                                         | valid/ready
//  req     | in  | kind, now_ms, order_volume                          | valid/ready
//  rsp     | out | status, orders_in_window, volume_in_window          | valid/ready
//
// Check: walks the order log, then the volume log, then finishes in S_DONE (bypass goes
// straight to S_DONE; only one log is walked when only one is enabled or the order log rejects).
// Sent: S_SENT, then S_DONE. Eviction walks one log entry per cycle through one time comparator.
// Reset empties both logs at once; log RAM contents are not cleared.
// A finished result waits in the output register; the sequencer holds until it is free.
module sliding_window_rate_limiter #(
	parameter int unsigned ORDER_LOG_DEPTH  = swrl_pkg::ORDER_LOG_DEPTH,
	parameter int unsigned VOLUME_LOG_DEPTH = swrl_pkg::VOLUME_LOG_DEPTH
) (
	input logic         clk,
	input logic         arst_n,
	swrl_cfg_if.sink    cfg,
	swrl_req_if.sink    req,
	swrl_rsp_if.source  rsp
);

	`include "sliding_window_rate_limiter_assert.svh"

	localparam int unsigned OCW = $clog2(ORDER_LOG_DEPTH + 1);
	localparam int unsigned VCW = $clog2(VOLUME_LOG_DEPTH + 1);
	localparam int unsigned OW  = (OCW > swrl_pkg::OUT_CNT_W) ? OCW : swrl_pkg::OUT_CNT_W;
	localparam int unsigned TW  = swrl_pkg::TIME_W;
	localparam int unsigned RW  = swrl_pkg::RUNVOL_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_OEV_RD,
		S_OEV_CMP,
		S_VEV_RD,
		S_VEV_CMP,
		S_SENT,
		S_DONE
	} state_t;

	state_t                           state_q;
	swrl_pkg::status_t                status_q;
	logic [swrl_pkg::PERIOD_W-1:0]    period_q;
	logic [swrl_pkg::MAXORD_W-1:0]    max_orders_q;
	logic [swrl_pkg::MAXVOL_W-1:0]    max_volume_q;
	logic [TW-1:0]                    last_check_q;
	logic [TW-1:0]                    lower_q;
	logic [swrl_pkg::VOL_W-1:0]       vol_q;
	logic [RW-1:0]                    running_q;
	logic                             out_valid_q;
	logic [swrl_pkg::STATUS_W-1:0]    out_status_q;
	logic [swrl_pkg::OUT_CNT_W-1:0]   out_orders_q;
	logic [RW-1:0]                    out_volume_q;

	swrl_pkg::log_cmd_t               o_cmd;
	swrl_pkg::log_cmd_t               v_cmd;
	logic [TW-1:0]                    o_head;
	logic [swrl_pkg::VLOG_W-1:0]      v_head;
	logic [swrl_pkg::VLOG_W-1:0]      v_wr;
	logic [OCW-1:0]                   o_count;
	logic [VCW-1:0]                   v_count;
	logic                             o_full;
	logic                             v_full;

	logic                             bypass;
	logic [TW-1:0]                    lower_next;
	logic [TW-1:0]                    cmp_time;
	logic                             time_le;
	logic                             o_evict;
	logic                             v_evict;
	logic [OW-1:0]                    o_cnt_ext;
	logic                             o_at_limit;
	logic [RW-1:0]                    v_amt;
	logic [RW:0]                      sum;
	logic [RW-1:0]                    sum_sat;
	logic                             over_limit;
	logic [RW-1:0]                    sub_res;
	logic                             o_on;
	logic                             v_on;
	logic                             load_out;

	always_comb begin
		o_on       = (max_orders_q != '0);
		v_on       = (max_volume_q != '0);
		bypass     = (!o_on && !v_on) || (period_q == '0);
		lower_next = (req.now_ms > TW'(period_q)) ? req.now_ms - TW'(period_q) : '0;
		cmp_time   = (state_q == S_VEV_CMP) ? v_head[swrl_pkg::VLOG_W-1 -: TW] : o_head;
		time_le    = (cmp_time <= lower_q);
		o_evict    = (state_q == S_OEV_CMP) && (o_count != '0) && time_le;
		v_evict    = (state_q == S_VEV_CMP) && (v_count != '0) && time_le;
		o_cnt_ext  = OW'(o_count);
		o_at_limit = (o_cnt_ext >= OW'(max_orders_q));
		v_amt      = RW'(v_head[swrl_pkg::VOL_W-1:0]);
		sub_res    = (v_amt >= running_q) ? '0 : running_q - v_amt;
		sum        = (RW+1)'(running_q) + (RW+1)'(vol_q);
		sum_sat    = sum[RW] ? '1 : sum[RW-1:0];
		over_limit = (sum > (RW+1)'(max_volume_q));
		o_cmd.pop  = o_evict;
		o_cmd.push = (state_q == S_SENT) && o_on && !o_full;
		v_cmd.pop  = v_evict;
		v_cmd.push = (state_q == S_SENT) && v_on && !v_full;
		v_wr       = {last_check_q, vol_q};
		load_out   = (state_q == S_DONE) && (!out_valid_q || rsp.ready);
	end

	assign req.ready            = (state_q == S_IDLE);
	assign cfg.ready            = 1'b1;
	assign rsp.valid            = out_valid_q;
	assign rsp.status           = out_status_q;
	assign rsp.orders_in_window = out_orders_q;
	assign rsp.volume_in_window = out_volume_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q     <= '0;
			max_orders_q <= '0;
			max_volume_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				swrl_pkg::REG_PERIOD:     period_q     <= cfg.data[swrl_pkg::PERIOD_W-1:0];
				swrl_pkg::REG_MAX_ORDERS: max_orders_q <= cfg.data[swrl_pkg::MAXORD_W-1:0];
				swrl_pkg::REG_MAX_VOLUME: max_volume_q <= cfg.data[swrl_pkg::MAXVOL_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			status_q     <= swrl_pkg::STATUS_OK;
			last_check_q <= '0;
			lower_q      <= '0;
			vol_q        <= '0;
			running_q    <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= '0;
			out_orders_q <= '0;
			out_volume_q <= '0;
		end else begin
			if (rsp.ready && !load_out) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						vol_q <= req.order_volume;
						if (req.kind == swrl_pkg::KIND_SENT) begin
							state_q <= S_SENT;
						end else if (bypass) begin
							status_q <= swrl_pkg::STATUS_OK;
							state_q  <= S_DONE;
						end else begin
							last_check_q <= req.now_ms;
							lower_q      <= lower_next;
							state_q      <= o_on ? S_OEV_RD : S_VEV_RD;
						end
					end
				end
				S_OEV_RD: begin
					state_q <= S_OEV_CMP;
				end
				S_OEV_CMP: begin
					if (!o_evict) begin
						if (o_at_limit) begin
							status_q <= swrl_pkg::STATUS_LIMIT;
							state_q  <= S_DONE;
						end else if (o_full) begin
							status_q <= swrl_pkg::STATUS_FULL;
							state_q  <= S_DONE;
						end else if (v_on) begin
							state_q <= S_VEV_RD;
						end else begin
							status_q <= swrl_pkg::STATUS_OK;
							state_q  <= S_DONE;
						end
					end
				end
				S_VEV_RD: begin
					state_q <= S_VEV_CMP;
				end
				S_VEV_CMP: begin
					if (v_evict) begin
						running_q <= sub_res;
					end else begin
						if (over_limit) begin
							status_q <= swrl_pkg::STATUS_LIMIT;
						end else if (v_full) begin
							status_q <= swrl_pkg::STATUS_FULL;
						end else begin
							status_q <= swrl_pkg::STATUS_OK;
						end
						state_q <= S_DONE;
					end
				end
				S_SENT: begin
					if ((o_on && o_full) || (v_on && v_full)) begin
						status_q <= swrl_pkg::STATUS_FULL;
					end else begin
						status_q <= swrl_pkg::STATUS_OK;
					end
					if (v_cmd.push) begin
						running_q <= sum_sat;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (load_out) begin
						out_valid_q  <= 1'b1;
						out_status_q <= status_q;
						out_orders_q <= o_cnt_ext[swrl_pkg::OUT_CNT_W-1:0];
						out_volume_q <= running_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	swrl_log #(
		.WIDTH (TW),
		.DEPTH (ORDER_LOG_DEPTH)
	) u_order_log (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (o_cmd),
		.wr_data   (last_check_q),
		.head_data (o_head),
		.count     (o_count),
		.full      (o_full)
	);

	swrl_log #(
		.WIDTH (swrl_pkg::VLOG_W),
		.DEPTH (VOLUME_LOG_DEPTH)
	) u_volume_log (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (v_cmd),
		.wr_data   (v_wr),
		.head_data (v_head),
		.count     (v_count),
		.full      (v_full)
	);

	`SWRL_ASSERT_IMPLIES(a_pop_not_empty, clk, arst_n, o_cmd.pop || v_cmd.pop, !(o_cmd.pop && o_count == '0) && !(v_cmd.pop && v_count == '0))
	`SWRL_ASSERT_IMPLIES(a_push_has_room, clk, arst_n, o_cmd.push || v_cmd.push, !(o_cmd.push && o_full) && !(v_cmd.push && v_full))
	`SWRL_ASSERT_NEXT(a_done_loads_out, clk, arst_n, load_out, rsp.valid && state_q == S_IDLE)
	`SWRL_ASSERT_NEXT(a_evict_lowers_volume, clk, arst_n, v_cmd.pop, running_q <= $past(running_q))

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the sliding window rate limiter: random and directed traffic
module tb_top;
	import swrl_pkg::*;

	localparam int WATCHDOG_CYCLES = 5000;
	localparam int HOLD_CYCLES     = 600;

	typedef struct {
		logic                kind;
		logic [TIME_W-1:0]   now_ms;
		logic [VOL_W-1:0]    volume;
	} order_req_t;

	typedef struct {
		status_t               status;
		logic [OUT_CNT_W-1:0]  orders;
		logic [RUNVOL_W-1:0]   volume;
	} window_result_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	swrl_req_if req_if ();
	swrl_rsp_if rsp_if ();
	swrl_cfg_if cfg_if ();

	logic                   req_valid = 1'b0;
	logic                   req_kind  = KIND_CHECK;
	logic [TIME_W-1:0]      req_now   = '0;
	logic [VOL_W-1:0]       req_vol   = '0;
	logic                   rsp_ready = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = REG_PERIOD;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;

	assign req_if.valid        = req_valid;
	assign req_if.kind         = req_kind;
	assign req_if.now_ms       = req_now;
	assign req_if.order_volume = req_vol;
	assign rsp_if.ready        = rsp_ready;
	assign cfg_if.valid        = cfg_valid;
	assign cfg_if.index        = cfg_index;
	assign cfg_if.data         = cfg_data;

	sliding_window_rate_limiter u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_if),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	order_req_t     order_requests[$];
	window_result_t window_results[$];

	logic req_fire   = 1'b0;
	logic cfg_fire   = 1'b0;
	logic rsp_fire   = 1'b0;
	logic failed     = 1'b0;
	logic quiet_run  = 1'b0;
	int   idle_cycles = 0;
	int   req_gap     = 0;
	int   rsp_stall   = 0;
	int   hold_left   = 0;
	int   hold_asks   = 0;
	int   hold_seen   = 0;
	logic [TIME_W-1:0] traffic_ms;

	// throttle state as the block should hold it
	logic [PERIOD_W-1:0]  lim_period = '0;
	logic [MAXORD_W-1:0]  lim_orders = '0;
	logic [MAXVOL_W-1:0]  lim_volume = '0;
	bit   [TIME_W-1:0]    ord_time_log [ORDER_LOG_DEPTH];
	logic [7:0]           ord_head = '0;
	logic [8:0]           ord_cnt  = '0;
	bit   [TIME_W-1:0]    vol_time_log [VOLUME_LOG_DEPTH];
	bit   [VOL_W-1:0]     vol_amt_log  [VOLUME_LOG_DEPTH];
	logic [7:0]           vol_head = '0;
	logic [8:0]           vol_cnt  = '0;
	logic [RUNVOL_W-1:0]  run_vol  = '0;
	logic [TIME_W-1:0]    last_check_ms = '0;

	function automatic status_t throttle_check(input logic [TIME_W-1:0] at_ms,
			input logic [VOL_W-1:0] vol);
		logic [TIME_W-1:0]   lower;
		logic [RUNVOL_W:0]   total;
		if ((lim_orders == 0 && lim_volume == 0) || lim_period == 0) begin
			return STATUS_OK;
		end
		last_check_ms = at_ms;
		lower = (at_ms > {16'b0, lim_period}) ? at_ms - {16'b0, lim_period} : '0;
		if (lim_orders != 0) begin
			while (ord_cnt > 0 && ord_time_log[ord_head] <= lower) begin
				ord_head = ord_head + 8'd1;
				ord_cnt  = ord_cnt - 9'd1;
			end
			if (ord_cnt >= lim_orders) begin
				return STATUS_LIMIT;
			end
			if (ord_cnt >= ORDER_LOG_DEPTH) begin
				return STATUS_FULL;
			end
		end
		if (lim_volume != 0) begin
			while (vol_cnt > 0 && vol_time_log[vol_head] <= lower) begin
				run_vol  = (vol_amt_log[vol_head] >= run_vol) ? '0 :
					run_vol - vol_amt_log[vol_head];
				vol_head = vol_head + 8'd1;
				vol_cnt  = vol_cnt - 9'd1;
			end
			total = {1'b0, run_vol} + vol;
			if (total > {1'b0, lim_volume}) begin
				return STATUS_LIMIT;
			end
			if (vol_cnt >= VOLUME_LOG_DEPTH) begin
				return STATUS_FULL;
			end
		end
		return STATUS_OK;
	endfunction

	function automatic status_t throttle_record_sent(input logic [VOL_W-1:0] vol);
		status_t           st;
		logic [7:0]        slot;
		logic [RUNVOL_W:0] total;
		st = STATUS_OK;
		if (lim_orders != 0) begin
			if (ord_cnt >= ORDER_LOG_DEPTH) begin
				st = STATUS_FULL;
			end else begin
				slot = ord_head + ord_cnt[7:0];
				ord_time_log[slot] = last_check_ms;
				ord_cnt = ord_cnt + 9'd1;
			end
		end
		if (lim_volume != 0) begin
			if (vol_cnt >= VOLUME_LOG_DEPTH) begin
				st = STATUS_FULL;
			end else begin
				slot = vol_head + vol_cnt[7:0];
				vol_time_log[slot] = last_check_ms;
				vol_amt_log[slot]  = vol;
				vol_cnt = vol_cnt + 9'd1;
				total   = {1'b0, run_vol} + vol;
				run_vol = total[RUNVOL_W] ? '1 : total[RUNVOL_W-1:0];
			end
		end
		return st;
	endfunction

	function automatic window_result_t throttle_step(input order_req_t it);
		window_result_t r;
		if (it.kind == KIND_CHECK) begin
			r.status = throttle_check(it.now_ms, it.volume);
		end else begin
			r.status = throttle_record_sent(it.volume);
		end
		r.orders = ord_cnt;
		r.volume = run_vol;
		return r;
	endfunction

	// monitor: handshakes, prediction, comparison, watchdog
	always @(posedge clk) begin
		window_result_t want;
		order_req_t     seen;
		req_fire = arst_n && req_valid && req_if.ready;
		cfg_fire = arst_n && cfg_valid && cfg_if.ready;
		rsp_fire = arst_n && rsp_if.valid && rsp_ready;
		if (req_fire) begin
			seen.kind   = req_kind;
			seen.now_ms = req_now;
			seen.volume = req_vol;
			window_results.push_back(throttle_step(seen));
		end
		if (cfg_fire) begin
			case (cfg_index)
				REG_PERIOD:     lim_period = cfg_data[PERIOD_W-1:0];
				REG_MAX_ORDERS: lim_orders = cfg_data[MAXORD_W-1:0];
				REG_MAX_VOLUME: lim_volume = cfg_data[MAXVOL_W-1:0];
				default: ;
			endcase
		end
		if (rsp_fire) begin
			if (window_results.size() == 0) begin
				$display("%0t: unexpected transaction: status %0d orders %0d volume %0d",
					$time, rsp_if.status, rsp_if.orders_in_window, rsp_if.volume_in_window);
				failed = 1'b1;
			end else begin
				want = window_results.pop_front();
				if (rsp_if.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d",
						$time, want.status, rsp_if.status);
					failed = 1'b1;
				end
				if (rsp_if.orders_in_window !== want.orders) begin
					$display("%0t: orders_in_window expected %0d actual %0d",
						$time, want.orders, rsp_if.orders_in_window);
					failed = 1'b1;
				end
				if (rsp_if.volume_in_window !== want.volume) begin
					$display("%0t: volume_in_window expected %0d actual %0d",
						$time, want.volume, rsp_if.volume_in_window);
					failed = 1'b1;
				end
			end
		end
		if (!arst_n || req_fire || cfg_fire || rsp_fire) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= WATCHDOG_CYCLES) begin
			$display("%0t: watchdog, no transaction for %0d cycles", $time, idle_cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// request driver
	always @(negedge clk) begin
		order_req_t nxt;
		logic       offer;
		if (arst_n && (!req_valid || req_fire)) begin
			offer = 1'b0;
			if (req_gap != 0) begin
				req_gap--;
			end else if (order_requests.size() != 0) begin
				if (!quiet_run && $urandom_range(0, 9) == 0) begin
					req_gap = $urandom_range(0, 7);
				end else begin
					nxt = order_requests.pop_front();
					offer = 1'b1;
					req_kind <= nxt.kind;
					req_now  <= nxt.now_ms;
					req_vol  <= nxt.volume;
				end
			end
			req_valid <= offer;
		end
	end

	// response ready: random stalls plus a long hold-off on request
	always @(negedge clk) begin
		logic rdy;
		rdy = 1'b0;
		if (hold_left != 0) begin
			hold_left--;
		end else if (hold_asks != hold_seen) begin
			hold_seen = hold_asks;
			hold_left = HOLD_CYCLES - 1;
		end else if (rsp_stall != 0) begin
			rsp_stall--;
		end else if (!quiet_run && $urandom_range(0, 7) == 0) begin
			rsp_stall = $urandom_range(0, 7);
		end else begin
			rdy = 1'b1;
		end
		rsp_ready <= rdy;
	end

	task automatic add_check(input logic [TIME_W-1:0] at_ms, input logic [VOL_W-1:0] vol);
		order_req_t it;
		it.kind   = KIND_CHECK;
		it.now_ms = at_ms;
		it.volume = vol;
		order_requests.push_back(it);
	endtask

	task automatic add_sent(input logic [VOL_W-1:0] vol);
		order_req_t it;
		it.kind   = KIND_SENT;
		it.now_ms = {16'($urandom), 32'($urandom)};
		it.volume = vol;
		order_requests.push_back(it);
	endtask

	function automatic logic [VOL_W-1:0] pick_volume();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2, 3:    return $urandom;
			default: return $urandom_range(0, 200);
		endcase
	endfunction

	// mostly check-then-sent pairs on a rising clock, with some noise
	task automatic add_random_traffic(input int count);
		order_req_t       it;
		logic [VOL_W-1:0] vol;
		int               made;
		made = 0;
		while (made < count) begin
			if ($urandom_range(0, 99) < 8) begin
				it.kind   = 1'($urandom_range(0, 1));
				it.now_ms = {16'($urandom), 32'($urandom)};
				it.volume = $urandom;
				order_requests.push_back(it);
				made++;
			end else begin
				vol = pick_volume();
				add_check(traffic_ms, vol);
				made++;
				if ($urandom_range(0, 3) != 0) begin
					add_sent(vol);
					made++;
				end
				traffic_ms = traffic_ms + TIME_W'($urandom_range(0, 30));
			end
		end
	endtask

	task automatic drain_block();
		do begin
			@(posedge clk);
		end while (order_requests.size() != 0 || req_valid || window_results.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		do begin
			@(negedge clk);
		end while (!cfg_fire);
		cfg_valid = 1'b0;
	endtask

	task automatic set_limits(input logic [PERIOD_W-1:0] period,
			input logic [MAXORD_W-1:0] max_orders, input logic [MAXVOL_W-1:0] max_volume);
		write_reg(REG_PERIOD, CFG_DATA_W'(period));
		write_reg(REG_MAX_ORDERS, CFG_DATA_W'(max_orders));
		write_reg(REG_MAX_VOLUME, CFG_DATA_W'(max_volume));
	endtask

	initial begin
		logic [TIME_W-1:0] far_ms;
		traffic_ms = {16'($urandom_range(0, 16'hFFF0)), 32'($urandom)};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset limits: everything bypassed
		add_check('0, '0);
		add_check('1, '1);
		add_sent('1);
		drain_block();

		set_limits(100, 2, 1000);
		add_check(50, 10);
		add_sent(10);
		add_check(60, 10);
		add_sent(500);
		add_check(70, 10);
		add_check(151, 10);
		add_check(152, 600);
		add_check(160, 0);
		add_sent(0);
		drain_block();

		// zero period bypasses checks, sent still logs
		set_limits(0, 1, 1);
		add_check(1000, 5);
		add_sent(7);
		drain_block();

		set_limits('1, 256, '1);
		add_check(10, '1);
		add_sent(3);
		drain_block();

		// fill both logs while the response side holds off
		add_check(traffic_ms, 1);
		hold_asks++;
		repeat (262) add_sent(pick_volume());
		add_check(traffic_ms + 5, 3);
		add_check(traffic_ms + 6, 0);
		drain_block();

		set_limits('1, 0, '1);
		add_check(traffic_ms + 7, 100);
		add_check(traffic_ms + 8, '1);
		add_sent(9);
		drain_block();

		// long eviction of both logs
		far_ms = traffic_ms + 48'h2_0000_0000;
		set_limits(5, 256, 1);
		add_check(far_ms, 0);
		add_check(far_ms + 1, 2);
		drain_block();
		traffic_ms = far_ms + 10;

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: set_limits(1, MAXORD_W'($urandom_range(1, 8)), 0);
				1: set_limits(50, 0, MAXVOL_W'($urandom_range(1, 5000)));
				2: set_limits($urandom_range(1, 200), MAXORD_W'($urandom_range(1, 16)),
					MAXVOL_W'($urandom_range(1, 100000)));
				3: set_limits($urandom, MAXORD_W'($urandom_range(0, 256)),
					{8'($urandom), 32'($urandom)});
				4: set_limits('1, 1, '1);
				default: set_limits(20, 256, 1);
			endcase
			add_random_traffic(30);
			drain_block();
		end

		quiet_run = 1'b1;
		set_limits($urandom_range(10, 100), MAXORD_W'($urandom_range(2, 20)),
			MAXVOL_W'($urandom_range(500, 50000)));
		add_random_traffic(40);
		drain_block();

		repeat (20) @(negedge clk);
		if (!failed && window_results.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
